FILE: design/stk_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stk_pkg: shared types and constants for the source tokeniser
// Token kinds, the keyword table, the token record and the queue push record.
// ---------------------------------------------------------------------------
package stk_pkg;

  // default saturation length of a number or identifier
  localparam int MAX_TOKEN_LEN_DEF = 64;

  // queue between scanner and output stage
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // token kinds
  localparam logic [3:0] TK_EOF     = 4'd0;
  localparam logic [3:0] TK_NUMBER  = 4'd1;
  localparam logic [3:0] TK_IDENT   = 4'd2;
  localparam logic [3:0] TK_ASSIGN  = 4'd3;
  localparam logic [3:0] TK_PLUS    = 4'd4;
  localparam logic [3:0] TK_MINUS   = 4'd5;
  localparam logic [3:0] TK_DCOLON  = 4'd6;
  localparam logic [3:0] TK_UNKNOWN = 4'd7;
  localparam logic [3:0] TK_KW_BASE = 4'd8;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // keyword table, zero padded to the longest keyword
  localparam int NKW    = 6;
  localparam int KW_MAX = 9;
  localparam logic [7:0] KW_TEXT [NKW][KW_MAX] = '{
    '{8'h49, 8'h4E, 8'h54, 8'h45, 8'h47, 8'h45, 8'h52, 8'h00, 8'h00}, // INTEGER
    '{8'h52, 8'h45, 8'h41, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // REAL
    '{8'h43, 8'h48, 8'h41, 8'h52, 8'h41, 8'h43, 8'h54, 8'h45, 8'h52}, // CHARACTER
    '{8'h50, 8'h52, 8'h4F, 8'h47, 8'h52, 8'h41, 8'h4D, 8'h00, 8'h00}, // PROGRAM
    '{8'h43, 8'h41, 8'h4C, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // CALL
    '{8'h50, 8'h52, 8'h49, 8'h4E, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00}  // PRINT
  };
  localparam logic [7:0] KW_LEN [NKW] = '{8'd7, 8'd4, 8'd9, 8'd7, 8'd4, 8'd5};

  // keyword character at a position, zero past its end
  function automatic logic [7:0] kw_char(input int idx, input logic [7:0] pos);
    logic [7:0] r;
    r = 8'h00;
    if (pos < 8'(KW_MAX)) r = KW_TEXT[idx][pos[3:0]];
    return r;
  endfunction

  // one token record
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [6:0]  length;
    logic        too_long;
    logic        last;
  } tok_t;

  // up to two tokens written into the queue in the same cycle
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  // queue status seen by the scanner and the output stage
  typedef struct packed {
    logic              room2;
    logic              nonempty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage
`default_nettype wire

FILE: design/stk_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stk_front: byte scanner
// Accepts one source byte an item, tracks line and column, classifies the
// byte and pushes the tokens it completes (up to two) into the queue.
// ---------------------------------------------------------------------------
module stk_front import stk_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] ch,
  input  wire qstat_t     qstat,
  output push_t           push
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  // scan modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_COLON = 2'd3;

  logic [1:0]       mode, mode_next;
  logic [15:0]      line_cnt, line_cnt_next;
  logic [15:0]      col_cnt, col_cnt_next;
  logic [15:0]      start_line, start_line_next;
  logic [15:0]      start_col, start_col_next;
  logic [LEN_W-1:0] run_len, run_len_next;
  logic [NKW-1:0]   kw_match, kw_match_next;
  logic             ovf, ovf_next;

  logic accept;
  logic is_dig, is_alp, is_sp, is_idc;
  logic [3:0] ident_kind;

  assign in_ready = qstat.room2;
  assign accept   = in_valid & in_ready;

  // byte classes
  assign is_dig = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_alp = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
  assign is_sp  = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
  assign is_idc = is_alp | is_dig | (ch == CH_UNDER);

  // kind of the identifier held in the run registers
  always_comb begin
    ident_kind = TK_IDENT;
    if (!ovf) begin
      for (int i = NKW - 1; i >= 0; i--) begin
        if (kw_match[i] && (8'(run_len) == KW_LEN[i])) ident_kind = TK_KW_BASE + 4'(i);
      end
    end
  end

  // next state and token generation
  always_comb begin
    tok_t t;
    logic done, do_ext, ext_ident, do_adv;
    logic [1:0] n;

    mode_next       = mode;
    line_cnt_next   = line_cnt;
    col_cnt_next    = col_cnt;
    start_line_next = start_line;
    start_col_next  = start_col;
    run_len_next    = run_len;
    kw_match_next   = kw_match;
    ovf_next        = ovf;
    push            = '0;
    t               = '0;
    n               = 2'd0;
    done            = 1'b0;
    do_ext          = 1'b0;
    ext_ident       = 1'b0;
    do_adv          = 1'b0;

    // close or continue the current run
    unique case (mode)
      MODE_NUM: begin
        if (is_dig) begin
          do_ext = 1'b1;
          do_adv = 1'b1;
          done   = 1'b1;
        end else begin
          t = '{TK_NUMBER, start_line, start_col, 7'(run_len), ovf, 1'b0};
          push.t0   = t;
          n         = 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (is_idc) begin
          do_ext    = 1'b1;
          ext_ident = 1'b1;
          do_adv    = 1'b1;
          done      = 1'b1;
        end else begin
          t = '{ident_kind, start_line, start_col, 7'(run_len), ovf, 1'b0};
          push.t0   = t;
          n         = 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_COLON: begin
        mode_next = MODE_IDLE;
        if (ch == CH_COLON) begin
          t = '{TK_DCOLON, start_line, start_col, 7'd2, 1'b0, 1'b0};
          do_adv = 1'b1;
          done   = 1'b1;
        end else begin
          t = '{TK_UNKNOWN, start_line, start_col, 7'd1, 1'b0, 1'b0};
        end
        push.t0 = t;
        n       = 2'd1;
      end
      default: ;
    endcase

    // byte not taken by a run: start something new
    if (!done) begin
      t = '{TK_UNKNOWN, line_cnt, col_cnt, 7'd1, 1'b0, 1'b0};
      if (ch == CH_NUL) begin
        t.kind   = TK_EOF;
        t.length = 7'd0;
        line_cnt_next = 16'd1;
        col_cnt_next  = 16'd1;
      end else if (is_sp) begin
        do_adv = 1'b1;
      end else if (is_dig || is_alp || (ch == CH_UNDER) || (ch == CH_COLON)) begin
        mode_next       = is_dig ? MODE_NUM : (ch == CH_COLON) ? MODE_COLON : MODE_IDENT;
        start_line_next = line_cnt;
        start_col_next  = col_cnt;
        run_len_next    = '0;
        kw_match_next   = '1;
        ovf_next        = 1'b0;
        do_ext          = (ch != CH_COLON);
        ext_ident       = !is_dig;
        do_adv          = 1'b1;
      end else begin
        if (ch == CH_EQ) t.kind = TK_ASSIGN;
        else if (ch == CH_PLUS) t.kind = TK_PLUS;
        else if (ch == CH_MINUS) t.kind = TK_MINUS;
        do_adv = 1'b1;
      end
      // tokens the byte makes by itself
      if ((ch == CH_NUL) || !(is_sp || is_idc || (ch == CH_COLON))) begin
        if (n == 2'd0) push.t0 = t;
        else push.t1 = t;
        n = n + 2'd1;
      end
    end

    // extend the run by one character, or mark it overflowed once it is at the maximum length
    if (do_ext) begin
      if (run_len_next >= LEN_W'(MAX_TOKEN_LEN)) begin
        ovf_next      = 1'b1;
        kw_match_next = '0;
      end else begin
        if (ext_ident) begin
          for (int i = 0; i < NKW; i++) begin
            if (kw_char(i, 8'(run_len_next)) != ch) kw_match_next[i] = 1'b0;
          end
        end
        run_len_next = run_len_next + 1'b1;
      end
    end

    // line and column, saturating
    if (do_adv) begin
      if (ch == CH_LF) begin
        if (line_cnt != 16'hFFFF) line_cnt_next = line_cnt + 16'd1;
        col_cnt_next = 16'd1;
      end else if (col_cnt != 16'hFFFF) begin
        col_cnt_next = col_cnt + 16'd1;
      end
    end

    // mark the final token of this byte
    push.t0.last = (n == 2'd1);
    push.t1.last = (n == 2'd2);
    push.n       = accept ? n : 2'd0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      line_cnt   <= 16'd1;
      col_cnt    <= 16'd1;
      start_line <= '0;
      start_col  <= '0;
      run_len    <= '0;
      kw_match   <= '1;
      ovf        <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      line_cnt   <= line_cnt_next;
      col_cnt    <= col_cnt_next;
      start_line <= start_line_next;
      start_col  <= start_col_next;
      run_len    <= run_len_next;
      kw_match   <= kw_match_next;
      ovf        <= ovf_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/stk_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stk_queue: token queue
// Small circular buffer that takes up to two tokens and gives one a cycle while popped.
// ---------------------------------------------------------------------------
module stk_queue import stk_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire logic  pop,
  output tok_t       head,
  output qstat_t     qstat
);

  tok_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head           = mem[rd_ptr];
  assign qstat.count    = count;
  assign qstat.nonempty = (count != '0);
  assign qstat.room2    = (count <= QCNT_W'(QDEPTH - 2));

  // storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.t0;
    if (push.n == 2'd2) mem[wr_ptr + 1'b1] <= push.t1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/stk_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stk_back: output stage
// Pulls tokens from the queue into the output register and packs them
// onto the result stream.
// ---------------------------------------------------------------------------
module stk_back import stk_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire qstat_t qstat,
  input  wire tok_t   head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [39:0] out_data,
  output logic [3:0]  out_user,
  output logic        out_last
);

  tok_t out_tok;

  // load whenever the queue holds a token and the register is free or being emptied
  assign pop = qstat.nonempty & (!out_valid | out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= qstat.nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_tok <= head;
  end

  // stream packing
  assign out_data = {out_tok.too_long, out_tok.length, out_tok.column, out_tok.line};
  assign out_user = out_tok.kind;
  assign out_last = out_tok.last;

endmodule
`default_nettype wire

FILE: design/source_tokenizer_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// source_tokenizer_top: streaming source tokeniser
// One source byte an item in, tokens with kind, position and length out.
// ---------------------------------------------------------------------------
// A token completed by an accepted byte is written to the token queue, then
// loaded into the output register and offered. One byte a cycle is taken
// while the queue has room; a byte yielding two tokens puts both in the 4-entry
// token queue. Input ready drops while the queue has fewer than two free slots.
// Reset (synchronous, rst high): line and column to 1, scanner idle, queue
// and output register empty.
// ---------------------------------------------------------------------------
module source_tokenizer_top import stk_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] ch
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [15:0] token_line, [31:16] token_column,
                                          // [38:32] token_length, [39] too_long
  output logic [3:0]       m_axis_tuser,  // [3:0] token_kind
  output logic             m_axis_tlast   // last token of the input byte
);

  push_t  push;
  qstat_t qstat;
  tok_t   head;
  logic   pop;

  stk_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .ch       (s_axis_tdata),
    .qstat    (qstat),
    .push     (push)
  );

  stk_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  stk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("token queue overfilled");

  // an end-of-file token is empty and closes its byte
  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == TK_EOF)) |->
      (m_axis_tdata[38:32] == 7'd0) && m_axis_tlast)
    else $error("malformed end-of-file token");

  // a saturated token reports exactly the maximum length
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[39]) |-> (m_axis_tdata[38:32] == 7'(MAX_TOKEN_LEN)))
    else $error("overlong token with wrong length");

  // no push while the queue lacks room for two tokens
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> qstat.room2)
    else $error("push into a full token queue");

endmodule
`default_nettype wire
